// File: rtl/mbm_pkg.sv
package mbm_pkg;

    // default sizes
    localparam int PHASE_BITS_DEF          = 32;
    localparam int TABLE_ADDR_BITS_DEF     = 10;
    localparam int SAMPLE_BITS_DEF         = 16;
    localparam int MAX_SAMPLES_PER_BIT_DEF = 64;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int SPB_BITS      = 7;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CARRIER_STEP  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FSK_STEP_ONE  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FSK_STEP_ZERO = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPB           = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_PHASE   = 3'd5;

    // modulation modes
    localparam logic [1:0] MODE_AM   = 2'd0;
    localparam logic [1:0] MODE_QPSK = 2'd1;
    localparam logic [1:0] MODE_FSK  = 2'd2;

    localparam logic [SPB_BITS-1:0] SPB_RESET = 7'd8;

    // quarter-wave table generation, fixed point Q30
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic [1:0]               mode;
        logic [CFG_DATA_BITS-1:0] carrier_step;
        logic [CFG_DATA_BITS-1:0] fsk_step_one;
        logic [CFG_DATA_BITS-1:0] fsk_step_zero;
        logic [SPB_BITS-1:0]      samples_per_bit;
        logic [CFG_DATA_BITS-1:0] start_phase;
    } cfg_t;

    // control carried along with one sample
    typedef struct packed {
        logic valid;
        logic bit_a;
        logic bit_b;
        logic symbol_done;
        logic burst_done;
        logic sin_neg;
        logic cos_neg;
    } ctrl_t;

    // one series term: product divided by its fixed divisor
    function automatic longint horner_div(input int i, input longint p);
        longint q;
        case (i)
            0:       q = p / 156;
            1:       q = p / 110;
            2:       q = p / 72;
            3:       q = p / 42;
            4:       q = p / 20;
            default: q = p / 6;
        endcase
        return q;
    endfunction

    // sine magnitude of entry r of a quarter wave with 2^qbits steps
    function automatic longint quarter_sine(input longint r, input int qbits,
                                            input longint unit);
        longint x;
        longint x2;
        longint t;
        longint s;
        longint v;
        x  = (r * HALF_PI_Q30 + ((64'sd1 <<< qbits) >>> 1)) >>> qbits;
        x2 = (x * x + (Q30_ONE >>> 1)) >>> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            t = Q30_ONE - horner_div(i, (x2 * t) >>> 30);
        end
        s = (x * t) >>> 30;
        v = (s * unit + (Q30_ONE >>> 1)) >>> 30;
        if (v > unit) begin
            v = unit;
        end
        if (v < 0) begin
            v = 0;
        end
        return v;
    endfunction

endpackage

// File: rtl/mbm_sine_rom.sv
module mbm_sine_rom #(
    parameter int QTR_BITS = mbm_pkg::TABLE_ADDR_BITS_DEF - 2,
    parameter int MAG_BITS = mbm_pkg::SAMPLE_BITS_DEF - 2
) (
    input  logic                clk,
    input  logic                en,
    input  logic [QTR_BITS:0]   sin_idx,
    input  logic [QTR_BITS:0]   cos_idx,
    output logic [MAG_BITS-1:0] sin_mag,
    output logic [MAG_BITS-1:0] cos_mag
);

    localparam int     QTR_SIZE = 1 << QTR_BITS;
    localparam longint UNIT     = (64'sd1 <<< MAG_BITS) - 64'sd1;

    logic [MAG_BITS-1:0] rom_tbl [QTR_SIZE+1];
    logic [MAG_BITS-1:0] sin_mag_reg;
    logic [MAG_BITS-1:0] cos_mag_reg;

    // constant quarter-wave contents
    for (genvar g = 0; g <= QTR_SIZE; g++) begin : g_rom
        localparam logic [MAG_BITS-1:0] ENTRY =
            MAG_BITS'(mbm_pkg::quarter_sine(longint'(g), QTR_BITS, UNIT));
        assign rom_tbl[g] = ENTRY;
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= rom_tbl[sin_idx];
            cos_mag_reg <= rom_tbl[cos_idx];
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;

endmodule

// File: rtl/mbm_gen.sv
module mbm_gen #(
    parameter int PHASE_BITS          = mbm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS     = mbm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_SAMPLES_PER_BIT = mbm_pkg::MAX_SAMPLES_PER_BIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mbm_pkg::cfg_t              cfg,
    input  logic                       en,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_bit_a,
    input  logic                       in_bit_b,
    input  logic                       in_restart,
    input  logic                       in_last,
    output logic [TABLE_ADDR_BITS-2:0] sin_idx,
    output logic [TABLE_ADDR_BITS-2:0] cos_idx,
    output mbm_pkg::ctrl_t             ctrl
);

    localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
    localparam int CNT_W    = (MAX_SAMPLES_PER_BIT > 1) ? $clog2(MAX_SAMPLES_PER_BIT) : 1;
    localparam logic [mbm_pkg::SPB_BITS-1:0] SPB_MAX =
        mbm_pkg::SPB_BITS'(MAX_SAMPLES_PER_BIT);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       a_reg, b_reg, last_reg;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic [mbm_pkg::SPB_BITS-1:0] spb_clip;
    logic [CNT_W-1:0]           cnt_last;
    logic                       issue;
    logic                       end_sample;
    logic                       accept;
    logic [PHASE_BITS-1:0]      step;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [1:0]                 sin_quad;
    logic [1:0]                 cos_quad;
    logic [QTR_BITS-1:0]        r;
    logic [QTR_BITS:0]          r_mirror;

    // samples per symbol, clipped to 1..max
    always_comb
    begin
        spb_clip = cfg.samples_per_bit;
        if (spb_clip == '0)
        begin
            spb_clip = mbm_pkg::SPB_BITS'(1);
        end
        else if (spb_clip > SPB_MAX)
        begin
            spb_clip = SPB_MAX;
        end
    end

    assign cnt_last   = CNT_W'(spb_clip - mbm_pkg::SPB_BITS'(1));
    assign issue      = busy_reg && en;
    assign end_sample = (cnt_reg == cnt_last);
    assign in_ready   = !busy_reg || (en && end_sample);
    assign accept     = in_valid && in_ready;

    // phase increment per sample
    always_comb
    begin
        case (cfg.mode)
            mbm_pkg::MODE_FSK:
            begin
                step = a_reg ? PHASE_BITS'(cfg.fsk_step_one) : PHASE_BITS'(cfg.fsk_step_zero);
            end
            default:
            begin
                step = PHASE_BITS'(cfg.carrier_step);
            end
        endcase
    end

    // symbol sequencing and phase update
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (issue)
        begin
            phase_next = phase_reg + step;
            if (end_sample)
            begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            if (in_restart)
            begin
                phase_next = PHASE_BITS'(cfg.start_phase);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // symbol bits, held for the symbol
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= in_bit_a;
            b_reg    <= in_bit_b;
            last_reg <= in_last;
        end
    end

    // quarter-wave addressing for sin and cos
    assign addr     = phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign sin_quad = addr[TABLE_ADDR_BITS-1 -: 2];
    assign cos_quad = sin_quad + 2'd1;
    assign r        = addr[QTR_BITS-1:0];
    assign r_mirror = (QTR_BITS+1)'(1 << QTR_BITS) - {1'b0, r};
    assign sin_idx  = sin_quad[0] ? r_mirror : {1'b0, r};
    assign cos_idx  = cos_quad[0] ? r_mirror : {1'b0, r};

    // control for the sample issued this cycle
    always_comb
    begin
        ctrl.valid       = issue;
        ctrl.bit_a       = a_reg;
        ctrl.bit_b       = b_reg;
        ctrl.symbol_done = end_sample;
        ctrl.burst_done  = end_sample && last_reg;
        ctrl.sin_neg     = sin_quad[1];
        ctrl.cos_neg     = cos_quad[1];
    end

endmodule

// File: rtl/multimode_bit_modulator.sv
// multimode bit modulator: oscillator with a quarter-wave sine table
// input word (s_*): tdata bit 0 is bit_a, bit 1 is bit_b; tuser is restart,
// which loads start_phase before the symbol; tlast is last_bit of a burst
// output word (m_*): tdata holds sample_real then sample_imag; tuser is
// symbol_done; tlast is burst_done (last sample of the burst's last symbol)
// each symbol gives samples_per_bit words (1..MAX_SAMPLES_PER_BIT), one per
// cycle while m_tready does not hold the pipe; the next symbol is taken in
// the cycle its predecessor's last sample leaves the sequencer, so symbols
// follow without gaps
// the first sample of a symbol passes the sequencer's phase register, the
// table read port and the output register before it is valid
// configuration: cfg_we, cfg_addr (register index), cfg_data; write only
// while idle; reset gives mode 0, all steps 0, samples_per_bit 8, phase 0
// a stalled m_tready while an output word is held freezes the whole pipe,
// table reads included; the sequencer keeps its place and no sample is lost or repeated
module multimode_bit_modulator #(
    parameter int PHASE_BITS          = mbm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS     = mbm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS         = mbm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES_PER_BIT = mbm_pkg::MAX_SAMPLES_PER_BIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [mbm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // bit_a, bit_b, zero fill
    input  logic                              s_tuser,  // restart
    input  logic                              s_tlast,  // last_bit
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // sample_real, sample_imag, zero fill
    output logic                              m_tuser,  // symbol_done
    output logic                              m_tlast   // burst_done
);

    localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
    localparam int MAG_BITS = SAMPLE_BITS - 2;
    localparam int TD_BITS  = ((2*SAMPLE_BITS+7)/8)*8;

    mbm_pkg::cfg_t  cfg_reg;
    mbm_pkg::ctrl_t gen_ctrl;
    mbm_pkg::ctrl_t s1_ctrl_reg;
    logic                   en;
    logic [QTR_BITS:0]      sin_idx;
    logic [QTR_BITS:0]      cos_idx;
    logic [MAG_BITS-1:0]    sin_mag;
    logic [MAG_BITS-1:0]    cos_mag;
    logic signed [SAMPLE_BITS-1:0] sin_val;
    logic signed [SAMPLE_BITS-1:0] cos_val;
    logic signed [SAMPLE_BITS-1:0] re_next;
    logic signed [SAMPLE_BITS-1:0] im_next;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] re_reg;
    logic [SAMPLE_BITS-1:0] im_reg;
    logic                   sym_done_reg;
    logic                   burst_done_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= mbm_pkg::MODE_AM;
            cfg_reg.carrier_step    <= '0;
            cfg_reg.fsk_step_one    <= '0;
            cfg_reg.fsk_step_zero   <= '0;
            cfg_reg.samples_per_bit <= mbm_pkg::SPB_RESET;
            cfg_reg.start_phase     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                mbm_pkg::REG_MODE:          cfg_reg.mode <= cfg_data[1:0];
                mbm_pkg::REG_CARRIER_STEP:  cfg_reg.carrier_step <= cfg_data;
                mbm_pkg::REG_FSK_STEP_ONE:  cfg_reg.fsk_step_one <= cfg_data;
                mbm_pkg::REG_FSK_STEP_ZERO: cfg_reg.fsk_step_zero <= cfg_data;
                mbm_pkg::REG_SPB:
                    cfg_reg.samples_per_bit <= cfg_data[mbm_pkg::SPB_BITS-1:0];
                mbm_pkg::REG_START_PHASE:   cfg_reg.start_phase <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // whole pipe advances unless the output word is held
    assign en = !out_valid_reg || m_tready;

    mbm_gen #(
        .PHASE_BITS          (PHASE_BITS),
        .TABLE_ADDR_BITS     (TABLE_ADDR_BITS),
        .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT)
    ) u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_bit_a   (s_tdata[0]),
        .in_bit_b   (s_tdata[1]),
        .in_restart (s_tuser),
        .in_last    (s_tlast),
        .sin_idx    (sin_idx),
        .cos_idx    (cos_idx),
        .ctrl       (gen_ctrl)
    );

    mbm_sine_rom #(
        .QTR_BITS (QTR_BITS),
        .MAG_BITS (MAG_BITS)
    ) u_rom (
        .clk     (clk),
        .en      (en),
        .sin_idx (sin_idx),
        .cos_idx (cos_idx),
        .sin_mag (sin_mag),
        .cos_mag (cos_mag)
    );

    // control aligned with the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctrl_reg <= gen_ctrl;
        end
    end

    // signed sin and cos from the quarter-wave magnitudes
    assign sin_val = s1_ctrl_reg.sin_neg ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});
    assign cos_val = s1_ctrl_reg.cos_neg ? -$signed({2'b00, cos_mag}) : $signed({2'b00, cos_mag});

    // mode mapping
    always_comb
    begin
        re_next = '0;
        im_next = '0;
        case (cfg_reg.mode)
            mbm_pkg::MODE_AM:
            begin
                re_next = s1_ctrl_reg.bit_a ? (cos_val <<< 1) : cos_val;
            end
            mbm_pkg::MODE_QPSK:
            begin
                re_next = s1_ctrl_reg.bit_a ? cos_val : -cos_val;
                im_next = s1_ctrl_reg.bit_b ? sin_val : -sin_val;
            end
            mbm_pkg::MODE_FSK:
            begin
                re_next = cos_val;
            end
            default:
            begin
                re_next = '0;
                im_next = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s1_ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_ctrl_reg.valid)
        begin
            re_reg         <= re_next;
            im_reg         <= im_next;
            sym_done_reg   <= s1_ctrl_reg.symbol_done;
            burst_done_reg <= s1_ctrl_reg.burst_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TD_BITS'({im_reg, re_reg});
    assign m_tuser  = sym_done_reg;
    assign m_tlast  = burst_done_reg;

endmodule
